// File: rtl/core/sbmck_pkg.sv
`default_nettype none

package sbmck_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // Payload widths
  localparam int COLOR_W      = 4;
  localparam int ATTR_W       = 8;
  localparam int CELL_INDEX_W = 16;

  // Sides are held in a width that covers every sprite size up to 256
  localparam int SIDE_W = 9;

  // Linear index math: covers (510 * 256) + 255 + 510 and a cell store of 2**20
  localparam int IDX_W = 21;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_START_X       = 3'd1,
    REG_START_Y       = 3'd2,
    REG_SPRITE_WIDTH  = 3'd3,
    REG_SPRITE_HEIGHT = 3'd4,
    REG_MIRROR        = 3'd5,
    REG_KEY_ENABLE    = 3'd6,
    REG_KEY_COLOR     = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/core/sbmck_walk.sv
`default_nettype none

module sbmck_walk #(
  parameter int MAX_SPRITE_SIDE = 64,
  parameter int CNT_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [6:0]       sprite_width,
  input  wire logic [6:0]       sprite_height,
  input  wire logic             mirror,
  output logic      [CNT_W-1:0] dcol,
  output logic      [CNT_W-1:0] row,
  output logic                  last
);
  import sbmck_pkg::*;

  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(MAX_SPRITE_SIDE);

  logic [CNT_W-1:0]  col_count;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  col_count_next;
  logic [CNT_W-1:0]  row_count_next;
  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic [SIDE_W-1:0] w_m1;
  logic [SIDE_W-1:0] h_m1;
  logic [CNT_W-1:0]  col;
  logic              col_wrap;
  logic              row_wrap;

  // Clamp the sizes into 1..MAX_SPRITE_SIDE
  always_comb begin
    w_eff = SIDE_W'(sprite_width);
    h_eff = SIDE_W'(sprite_height);
    if (w_eff == '0) begin
      w_eff = SIDE_W'(1);
    end else if (w_eff > MAX_SIDE) begin
      w_eff = MAX_SIDE;
    end
    if (h_eff == '0) begin
      h_eff = SIDE_W'(1);
    end else if (h_eff > MAX_SIDE) begin
      h_eff = MAX_SIDE;
    end
    w_m1 = w_eff - SIDE_W'(1);
    h_m1 = h_eff - SIDE_W'(1);
  end

  // Pull a counter left beyond a shrunken size back to the last position
  always_comb begin
    col = (SIDE_W'(col_count) >= w_eff) ? CNT_W'(w_m1) : col_count;
    row = (SIDE_W'(row_count) >= h_eff) ? CNT_W'(h_m1) : row_count;
    col_wrap = (SIDE_W'(col) == w_m1);
    row_wrap = (SIDE_W'(row) == h_m1);
    last = col_wrap && row_wrap;
    dcol = mirror ? CNT_W'(w_m1 - SIDE_W'(col)) : col;
  end

  always_comb begin
    if (col_wrap) begin
      col_count_next = '0;
      row_count_next = row_wrap ? '0 : row + CNT_W'(1);
    end else begin
      col_count_next = col + CNT_W'(1);
      row_count_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (advance) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

`ifndef SYNTHESIS
  a_wrap_to_origin: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> col_count == '0 && row_count == '0)
    else $error("walk did not return to origin after last pixel");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(col_count) && $stable(row_count))
    else $error("counters moved without an accepted pixel");

  a_dcol_in_sprite: assert property (@(posedge clk) disable iff (rst)
    SIDE_W'(dcol) < w_eff && SIDE_W'(row) < h_eff)
    else $error("position outside sprite");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sprite_blit_mirror_color_key.sv
// Sprite blitter: turns a stream of sprite pixels into text-cell writes.
// Input channel (in_valid / in_stall / pixel_color): one pixel per
// transaction, in row-major sprite order. Output channel (out_valid /
// out_stall / cell_index, attribute, attribute_write, sprite_done,
// out_of_range): one cell-pair write per pixel that lands on or below the
// screen top; pixels of rows above the top give no transaction.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while the block is empty.
// Pipeline: two register stages from port to port (input register, then
// result register holding the 9x9 multiply and index add).
// Throughput: 1 pixel per cycle while out_stall is low.
// Stall: a stalled result holds; the input register still takes one more
// pixel, then in_stall rises until the result register frees up.
// Reset: registers return to 80, 0, 0, 8, 8, 0, 0, 0; the column and row
// counters return to the sprite origin; both stages empty.
`default_nettype none

module sprite_blit_mirror_color_key #(
  parameter int MAX_SPRITE_SIDE = 64,
  parameter int SCREEN_CELLS    = 65536
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sbmck_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sbmck_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [sbmck_pkg::COLOR_W-1:0]       pixel_color,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [sbmck_pkg::CELL_INDEX_W-1:0]  cell_index,
  output logic      [sbmck_pkg::ATTR_W-1:0]        attribute,
  output logic                                     attribute_write,
  output logic                                     sprite_done,
  output logic                                     out_of_range
);
  import sbmck_pkg::*;

  localparam int CNT_W = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1;
  localparam logic [IDX_W-1:0] LAST_FIT = IDX_W'(SCREEN_CELLS - 1);

  // Configuration registers
  logic [8:0]         screen_width;
  logic [7:0]         start_x;
  logic [8:0]         start_y;
  logic [6:0]         sprite_width;
  logic [6:0]         sprite_height;
  logic               mirror;
  logic               key_enable;
  logic [COLOR_W-1:0] key_color;

  // Input stage
  logic               s1_valid;
  logic [COLOR_W-1:0] s1_color;
  logic [CNT_W-1:0]   s1_dcol;
  logic [CNT_W-1:0]   s1_row;
  logic               s1_last;

  logic               in_accept;
  logic               s2_free;
  logic               s1_move;
  logic [CNT_W-1:0]   walk_dcol;
  logic [CNT_W-1:0]   walk_row;
  logic               walk_last;

  // Index math
  logic [9:0]         drow;
  logic               keep;
  logic [17:0]        row_base;
  logic [IDX_W-1:0]   idx;
  logic               oor;
  logic               transparent;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 9'd80;
      start_x       <= '0;
      start_y       <= '0;
      sprite_width  <= 7'd8;
      sprite_height <= 7'd8;
      mirror        <= 1'b0;
      key_enable    <= 1'b0;
      key_color     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_START_X:       start_x       <= cfg_data[7:0];
        REG_START_Y:       start_y       <= cfg_data;
        REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[6:0];
        REG_SPRITE_HEIGHT: sprite_height <= cfg_data[6:0];
        REG_MIRROR:        mirror        <= cfg_data[0];
        REG_KEY_ENABLE:    key_enable    <= cfg_data[0];
        REG_KEY_COLOR:     key_color     <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or being taken;
  // the input register moves on whenever the result register frees.
  assign s2_free   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s2_free;
  assign in_accept = in_valid && !in_stall;
  assign s1_move   = s1_valid && s2_free;

  // Walk the sprite: counters advance once per accepted pixel
  sbmck_walk #(
    .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE),
    .CNT_W           (CNT_W)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .advance       (in_accept),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .mirror        (mirror),
    .dcol          (walk_dcol),
    .row           (walk_row),
    .last          (walk_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_color <= pixel_color;
      s1_dcol  <= walk_dcol;
      s1_row   <= walk_row;
      s1_last  <= walk_last;
    end
  end

  // Destination row: signed start row plus sprite row; negative means
  // above the screen top, so drop the pixel.
  always_comb begin
    drow        = {start_y[8], start_y} + 10'(s1_row);
    keep        = !drow[9];
    row_base    = drow[8:0] * screen_width;
    idx         = IDX_W'(row_base) + IDX_W'(start_x) + IDX_W'({s1_dcol, 1'b0});
    // The right cell of the pair must fit too
    oor         = idx >= LAST_FIT;
    transparent = key_enable && (s1_color == key_color);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      cell_index      <= oor ? '0 : idx[CELL_INDEX_W-1:0];
      attribute       <= {s1_color, s1_color};
      attribute_write <= !oor && !transparent;
      sprite_done     <= s1_last;
      out_of_range    <= oor;
    end
  end

`ifndef SYNTHESIS
  a_oor_drops_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> !attribute_write && cell_index == '0)
    else $error("out-of-range result still writes");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken with both stages held");

  a_held_pixel_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_free && !in_accept |=> !s1_valid)
    else $error("input stage failed to drain");
`endif

endmodule

`default_nettype wire
